/* rtl/core/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the streamed pattern search block.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int INDEX_BITS_DEF  = 16;

  localparam int BYTE_W     = 8;
  localparam int PAT_W      = 64;
  localparam int LEN_W      = 4;
  localparam int CNT_W      = 4;
  localparam int TBL_W      = 3;
  localparam int POS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic build;
    logic load;
    logic scan;
    logic commit;
  } kmp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic build_done;
    logic step_done;
    logic emit;
    logic out_free;
  } kmp_stat_t;

endpackage

/* rtl/core/kmp_if.sv */
// ----------------------------------------------------------------------------
// kmp_if
// Valid/ready channels for text words in and search result words out.
// ----------------------------------------------------------------------------
interface kmp_text_if;
  import kmp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface kmp_result_if;
  import kmp_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

/* rtl/core/kmp_datapath.sv */
// ----------------------------------------------------------------------------
// kmp_datapath
// Pattern registers, partial-match table, match state, index counter and
// the result register. Table build and text fallback share one table read.
// ----------------------------------------------------------------------------
module kmp_datapath #(
  parameter int PATTERN_MAX = kmp_pkg::PATTERN_MAX_DEF,
  parameter int INDEX_BITS  = kmp_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic [kmp_pkg::BYTE_W-1:0]       text_byte,
  input  logic                             last_byte,
  input  kmp_pkg::kmp_cmd_t                cmd,
  output kmp_pkg::kmp_stat_t               stat,
  kmp_result_if.source                     result
);
  import kmp_pkg::*;

  localparam int TIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int EXT_W  = (INDEX_BITS > POS_W) ? INDEX_BITS : POS_W;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};
  localparam logic [CNT_W-1:0]      LEN_MAX = CNT_W'(PATTERN_MAX);

  logic [PAT_W-1:0]      pattern;
  logic [LEN_W-1:0]      plen;
  logic [TBL_W-1:0]      tbl [PATTERN_MAX];
  logic [CNT_W-1:0]      bi;
  logic [CNT_W-1:0]      bk;
  logic [CNT_W-1:0]      k;
  logic [CNT_W-1:0]      matched;
  logic [INDEX_BITS-1:0] idx;
  logic                  match_seen;
  logic [BYTE_W-1:0]     cur_byte;
  logic                  cur_last;
  logic                  active;
  logic                  out_valid;
  logic                  found_q;
  logic [POS_W-1:0]      pos_q;

  logic [CNT_W-1:0]      n_eff;
  logic [CNT_W-1:0]      rd_k;
  logic [TIDX_W-1:0]     rd_idx;
  logic [TBL_W-1:0]      tbl_rd;
  logic                  b_eq;
  logic                  b_fall;
  logic [CNT_W-1:0]      b_nk;
  logic                  s_eq;
  logic                  s_fall;
  logic [CNT_W-1:0]      s_nk;
  logic                  hit;
  logic                  emit;
  logic [INDEX_BITS-1:0] start;
  logic [EXT_W-1:0]      start_ext;
  logic                  cfg_hit;

  function automatic logic [BYTE_W-1:0] pat_at(input logic [PAT_W-1:0] p,
                                               input logic [2:0] sel);
    return p[BYTE_W*sel +: BYTE_W];
  endfunction

  // length register clamped to 1..PATTERN_MAX
  always_comb begin
    if (plen == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(plen) > LEN_MAX) begin
      n_eff = LEN_MAX;
    end else begin
      n_eff = CNT_W'(plen);
    end
  end

  // single table read port, entry 0 is always zero
  assign rd_k   = cmd.build ? bk : k;
  assign rd_idx = TIDX_W'(rd_k - CNT_W'(1));
  assign tbl_rd = (rd_k <= CNT_W'(1)) ? '0 : tbl[rd_idx];

  // table build step
  assign b_eq   = pat_at(pattern, bi[2:0]) == pat_at(pattern, bk[2:0]);
  assign b_fall = (bk != '0) && !b_eq;
  assign b_nk   = bk + CNT_W'(b_eq);

  // text step
  assign s_eq   = pat_at(pattern, k[2:0]) == cur_byte;
  assign s_fall = active && (k != '0) && !s_eq;
  assign s_nk   = k + CNT_W'(s_eq);
  assign hit    = active && !s_fall && (s_nk >= n_eff);
  assign emit   = hit || (cur_last && !match_seen);

  assign start     = idx + INDEX_BITS'(1) - INDEX_BITS'(n_eff);
  assign start_ext = EXT_W'(start);

  assign cfg_hit = wr_en && ((wr_index == REG_PATTERN_BYTES) ||
                             (wr_index == REG_PATTERN_LENGTH));

  assign stat.build_done = bi >= n_eff;
  assign stat.step_done  = !s_fall;
  assign stat.emit       = emit;
  assign stat.out_free   = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern    <= '0;
      plen       <= LEN_W'(1);
      bi         <= CNT_W'(1);
      bk         <= '0;
      matched    <= '0;
      idx        <= '0;
      match_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_PATTERN_BYTES:  pattern <= wr_data[PAT_W-1:0];
          REG_PATTERN_LENGTH: plen    <= wr_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        bi      <= CNT_W'(1);
        bk      <= '0;
        matched <= '0;
      end else if (cmd.build && !stat.build_done) begin
        if (b_fall) begin
          bk <= CNT_W'(tbl_rd);
        end else begin
          bk <= b_nk;
          bi <= bi + CNT_W'(1);
        end
      end else if (cmd.commit) begin
        if (hit) begin
          match_seen <= 1'b1;
          matched    <= '0;
        end else if (active) begin
          matched <= s_nk;
        end
        if (idx != IDX_MAX) begin
          idx <= idx + INDEX_BITS'(1);
        end
        if (cur_last) begin
          matched    <= '0;
          idx        <= '0;
          match_seen <= 1'b0;
        end
      end
      if (cmd.commit && emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cfg_hit && cmd.build && !stat.build_done && !b_fall) begin
      tbl[bi[TIDX_W-1:0]] <= b_nk[TBL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_byte <= text_byte;
      cur_last <= last_byte;
      k        <= (matched >= n_eff) ? '0 : matched;
      active   <= !match_seen && (idx != IDX_MAX);
    end else if (cmd.scan && s_fall) begin
      k <= CNT_W'(tbl_rd);
    end
    if (cmd.commit && emit) begin
      found_q <= hit;
      pos_q   <= hit ? start_ext[POS_W-1:0] : '0;
    end
  end

  assign result.valid    = out_valid;
  assign result.found    = found_q;
  assign result.position = pos_q;

  a_matched_below_len: assert property (@(posedge clk) disable iff (rst)
    matched < n_eff)
    else $error("matched count reached pattern length");

  a_build_proper_prefix: assert property (@(posedge clk) disable iff (rst)
    bk < bi)
    else $error("table build prefix not proper");

  a_hit_sets_seen: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && hit && !cur_last && !cfg_hit) |=> match_seen)
    else $error("match not recorded");

endmodule

/* rtl/core/kmp_ctrl.sv */
// ----------------------------------------------------------------------------
// kmp_ctrl
// Sequencer: table build after reset or a register write, then one text
// word at a time through its fallback steps and commit.
// ----------------------------------------------------------------------------
module kmp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               text_valid,
  output logic               text_ready,
  input  kmp_pkg::kmp_stat_t stat,
  output kmp_pkg::kmp_cmd_t  cmd
);
  import kmp_pkg::*;

  typedef enum logic [2:0] {
    S_BUILD = 3'b001,
    S_IDLE  = 3'b010,
    S_SCAN  = 3'b100
  } kmp_state_t;

  kmp_state_t state;
  kmp_state_t state_next;

  assign text_ready = (state == S_IDLE) && !wr_en;

  assign cmd.build  = state == S_BUILD;
  assign cmd.load   = text_ready && text_valid;
  assign cmd.scan   = state == S_SCAN;
  assign cmd.commit = (state == S_SCAN) && stat.step_done &&
                      (!stat.emit || stat.out_free);

  always_comb begin
    state_next = state;
    case (state)
      S_BUILD: begin
        if (stat.build_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.load) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_BUILD;
    endcase
    // any register write returns the controller to table build
    if (wr_en) state_next = S_BUILD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BUILD;
    end else begin
      state <= state_next;
    end
  end

  a_write_rebuilds: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (state == S_BUILD))
    else $error("register write did not start table build");

  a_fallback_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && !stat.step_done && !wr_en) |=> (state == S_SCAN))
    else $error("left scan before fallback finished");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");

endmodule

/* rtl/core/kmp_first_match_finder.sv */
// ----------------------------------------------------------------------------
// kmp_first_match_finder
// Streamed first-match search of a pattern of up to eight bytes.
// ----------------------------------------------------------------------------
// After reset and after a write to the pattern bytes or length register the
// block derives its partial-match table, during which text is not accepted.
// Each text word is then accepted in the idle state and stepped and committed
// in the scan state, which repeats one table fallback per step on a mismatch;
// the fallback chain runs through the single table read port. A result waits
// in an output register; a word that needs to emit while that register is
// still full waits in the step stage. One result per text: found with the
// start position at the first match, or not-found at the last word.
module kmp_first_match_finder #(
  parameter int PATTERN_MAX = kmp_pkg::PATTERN_MAX_DEF,
  parameter int INDEX_BITS  = kmp_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [kmp_pkg::CFG_DATA_W-1:0] wr_data,
  kmp_text_if.sink                       text,
  kmp_result_if.source                   result
);
  import kmp_pkg::*;

  kmp_cmd_t  cmd;
  kmp_stat_t stat;
  logic      text_ready;

  assign text.ready = text_ready;

  kmp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .text_valid (text.valid),
    .text_ready (text_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  kmp_datapath #(
    .PATTERN_MAX (PATTERN_MAX),
    .INDEX_BITS  (INDEX_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .text_byte (text.text_byte),
    .last_byte (text.last_byte),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

/* test/kmp_first_match_finder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmp_first_match_finder_test
// Self-checking bench for the streamed first-match pattern search. A local
// prefix-table predictor follows every accepted text word and queues the
// search result it should cause; results are checked field by field in order.
// Covers directed corner cases, writes in the middle of a text, output
// backpressure and randomized patterns and texts.
// ----------------------------------------------------------------------------
module kmp_first_match_finder_test;
  import kmp_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 900;
  localparam int SETTLE_CYCLES = 40;
  localparam int BUILD_CYCLES  = 2 * (PATTERN_MAX_DEF - 1) + 6;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 10000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [POS_W-1:0]     INDEX_TOP   = '1;

  localparam logic [BYTE_W-1:0] CH_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_B = 8'h42;
  localparam logic [BYTE_W-1:0] CH_C = 8'h43;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_result_t;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN, SINK_SPARSE} sink_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  kmp_text_if   text_ch();
  kmp_result_if result_ch();

  kmp_first_match_finder dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .text     (text_ch),
    .result   (result_ch)
  );

  // predictor state
  logic [PAT_W-1:0] model_pattern;
  logic [LEN_W-1:0] model_length;
  logic [TBL_W-1:0] border_tbl [PATTERN_MAX_DEF];
  logic [CNT_W-1:0] prefix_len;
  logic [POS_W-1:0] text_pos;
  logic             hit_seen;
  search_result_t   expected_results[$];

  int          errors;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned write_count;
  int          idle_cycles;

  // sender and receiver control
  bit          offering;
  bit          steady_send;
  int unsigned burst_left;
  int unsigned gap_left;
  bit          hold_request;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned active_length();
    int unsigned n;
    n = 32'(model_length);
    if (n < 1) n = 1;
    if (n > PATTERN_MAX_DEF) n = PATTERN_MAX_DEF;
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_char(int unsigned k);
    return model_pattern[8 * (k % 8) +: 8];
  endfunction

  function automatic void derive_borders();
    int unsigned n;
    int unsigned k;
    n = active_length();
    k = 0;
    foreach (border_tbl[i]) border_tbl[i] = '0;
    for (int unsigned i = 1; i < n; i++) begin
      while (k > 0 && pattern_char(i) != pattern_char(k)) k = 32'(border_tbl[k - 1]);
      if (pattern_char(i) == pattern_char(k)) k++;
      border_tbl[i] = k[TBL_W-1:0];
    end
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_PATTERN_BYTES) begin
      model_pattern = data;
    end else if (idx == REG_PATTERN_LENGTH) begin
      model_length = data[LEN_W-1:0];
    end else begin
      return;
    end
    prefix_len = '0;
    derive_borders();
  endfunction

  function automatic void predict_word(logic [BYTE_W-1:0] c, logic last);
    int unsigned    n;
    int unsigned    k;
    bit             emitted;
    search_result_t r;
    n = active_length();
    emitted = 1'b0;
    if (!hit_seen && text_pos != INDEX_TOP) begin
      k = 32'(prefix_len);
      if (k >= n) k = 0;
      // fall back on the last matched character
      while (k > 0 && pattern_char(k) != c) k = 32'(border_tbl[k - 1]);
      if (pattern_char(k) == c) k++;
      if (k >= n) begin
        r.found = 1'b1;
        r.position = text_pos - POS_W'(n - 1);
        expected_results.push_back(r);
        hit_seen = 1'b1;
        prefix_len = '0;
        emitted = 1'b1;
      end else begin
        prefix_len = k[CNT_W-1:0];
      end
    end
    if (text_pos != INDEX_TOP) text_pos++;
    if (last) begin
      if (!emitted && !hit_seen) begin
        r.found = 1'b0;
        r.position = '0;
        expected_results.push_back(r);
      end
      prefix_len = '0;
      text_pos = '0;
      hit_seen = 1'b0;
    end
  endfunction

  task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
    if (!offering) begin
      repeat (gap_left) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.last_byte <= last;
    offering = 1'b1;
    do @(posedge clk); while (!text_ch.ready);
    predict_word(b, last);
    words_sent++;
    if (!steady_send) begin
      if (burst_left <= 1) begin
        text_ch.valid <= 1'b0;
        offering = 1'b0;
        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_text(input byte_q_t txt);
    foreach (txt[i]) send_word(txt[i], i == txt.size() - 1);
  endtask

  task automatic pause_text();
    if (offering) begin
      text_ch.valid <= 1'b0;
      offering = 1'b0;
      gap_left = 1;
    end
  endtask

  // sender stops until every queued result word is back, then lets the step finish
  task automatic drain_results();
    pause_text();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    apply_write(idx, data);
    write_count++;
    wr_en <= 1'b0;
    repeat (BUILD_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    drain_results();
    write_reg(REG_PATTERN_BYTES, '1);
    send_text('{8'h00, 8'hFF});   // match on the last byte
    send_text('{8'hFF, 8'h00});   // last byte after a match stays silent
    drain_results();
    write_reg(REG_PATTERN_LENGTH, '0);   // zero length acts as one
    write_reg(REG_PATTERN_BYTES, '0);
    send_text('{8'hFF});          // one-word text, no match
    drain_results();
    write_reg(REG_PATTERN_BYTES, 64'h4341_4241_4241_4241);
    write_reg(REG_PATTERN_LENGTH, 64'd15);  // clipped to eight
    send_text('{CH_A, CH_B, CH_A, CH_B, CH_A, CH_B, CH_A, CH_B, CH_A, CH_C});
  endtask

  task automatic test_mid_text_writes();
    drain_results();
    write_reg(REG_PATTERN_BYTES, 64'hA5A5_A5A5_A543_4241);
    write_reg(REG_PATTERN_LENGTH, 64'hFEDC_BA98_7654_3213);
    // unused indexes leave the partial match alone
    send_word(CH_A, 1'b0);
    send_word(CH_B, 1'b0);
    drain_results();
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '1);
    send_word(CH_C, 1'b0);
    // match already seen in this text: a rewrite keeps it silent
    drain_results();
    write_reg(REG_PATTERN_BYTES, 64'hA5A5_A5A5_A543_4241);
    send_text('{CH_A, CH_B, CH_C});
    // rewrite drops the partial match, search picks up again later
    send_word(CH_A, 1'b0);
    send_word(CH_B, 1'b0);
    drain_results();
    write_reg(REG_PATTERN_BYTES, 64'hA5A5_A5A5_A543_4241);
    send_text('{CH_C, CH_A, CH_B, CH_C});
  endtask

  task automatic test_fill_and_drain();
    drain_results();
    write_reg(REG_PATTERN_BYTES, 64'h5A);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    hold_request = 1'b1;
    repeat (40) send_text('{8'h5A});
    drain_results();
  endtask

  task automatic test_random_texts();
    int unsigned       first_word;
    int unsigned       texts;
    int unsigned       tlen;
    int unsigned       plen;
    int unsigned       at;
    int unsigned       pick;
    logic [BYTE_W-1:0] alphabet[3];
    logic [PAT_W-1:0]  pat;
    byte_q_t           txt;
    bit                noisy;
    first_word = words_sent;
    while (words_sent - first_word < RANDOM_ITEMS) begin
      drain_results();
      foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        pat = '0;
      end else if (pick == 1) begin
        pat = '1;
      end else if (pick == 2) begin
        pat = {$urandom, $urandom};
      end else begin
        for (int i = 0; i < 8; i++) pat[8 * i +: 8] = alphabet[$urandom_range(0, pick % 2 + 1)];
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_PATTERN_BYTES, pat);
      pick = $urandom_range(0, 19);
      if (pick < 16) write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(pick % 8 + 1));
      else write_reg(REG_PATTERN_LENGTH, {$urandom, $urandom});
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, {$urandom, $urandom});
      end
      steady_send = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) hold_request = 1'b1;
      texts = $urandom_range(3, 10);
      repeat (texts) begin
        plen = active_length();
        tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 16);
        noisy = ($urandom_range(0, 7) == 0);
        txt = {};
        repeat (tlen) begin
          if (noisy || $urandom_range(0, 5) == 0) txt.push_back(8'($urandom_range(0, 255)));
          else txt.push_back(pattern_char($urandom_range(0, plen - 1)));
        end
        if ($urandom_range(0, 1) == 1) begin
          // plant the pattern, now and then one character short
          pick = plen - ((plen > 1 && $urandom_range(0, 3) == 0) ? 1 : 0);
          while (txt.size() < pick) txt.push_back(8'h00);
          at = $urandom_range(0, txt.size() - pick);
          for (int unsigned i = 0; i < pick; i++) txt[at + i] = pattern_char(i);
        end
        send_text(txt);
      end
    end
    steady_send = 1'b0;
  endtask

  // result receiver with its own stall pattern and an occasional long hold
  initial begin
    int unsigned sink_left;
    int unsigned hold_left;
    int unsigned phase;
    sink_mode_t  sink_mode;
    result_ch.ready <= 1'b0;
    sink_left = 0;
    hold_left = 0;
    phase = 0;
    sink_mode = SINK_OPEN;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (sink_left == 0) begin
          sink_mode = sink_mode_t'($urandom_range(0, 3));
          sink_left = $urandom_range(16, 96);
        end
        sink_left--;
        case (sink_mode)
          SINK_OPEN:    result_ch.ready <= 1'b1;
          SINK_RANDOM:  result_ch.ready <= ($urandom_range(0, 3) != 0);
          SINK_PATTERN: result_ch.ready <= (phase % 7 < 5);
          default:      result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    search_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, found=%0b position=%0d", $time,
                 result_ch.found, result_ch.position);
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        if (want.found !== result_ch.found) begin
          errors++;
          $display("%0t: found mismatch, expected %0b, got %0b", $time, want.found,
                   result_ch.found);
        end
        if (want.position !== result_ch.position) begin
          errors++;
          $display("%0t: position mismatch, expected %0d, got %0d", $time, want.position,
                   result_ch.position);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || wr_en || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, expected_results.size());
      $display("FAIL kmp_first_match_finder");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    text_ch.valid <= 1'b0;
    text_ch.text_byte <= '0;
    text_ch.last_byte <= 1'b0;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    write_count = 0;
    idle_cycles = 0;
    offering = 1'b0;
    steady_send = 1'b0;
    burst_left = 0;
    gap_left = 1;
    hold_request = 1'b0;
    model_pattern = '0;
    model_length = 4'd1;
    prefix_len = '0;
    text_pos = '0;
    hit_seen = 1'b0;
    derive_borders();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_mid_text_writes();
    test_fill_and_drain();
    test_random_texts();
    drain_results();

    $display("covered %0d text words and %0d result words over %0d register writes,", words_sent,
             results_seen, write_count);
    $display("with mid-text rewrites, a long output hold and random patterns and texts");
    if (errors == 0) begin
      $display("PASS kmp_first_match_finder");
    end else begin
      $display("FAIL kmp_first_match_finder");
    end
    $finish;
  end

endmodule
